>>> hdl/gsdc_pkg.sv
package gsdc_pkg;

    localparam int PADS_DEF = 4;
    localparam int AXES     = 6;
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 16;
    localparam int DZ_W     = 14;
    localparam int TH_W     = 16;
    localparam int AX_W     = 17;
    localparam int IN_W     = 96;
    localparam int OUT_W    = 128;

    localparam logic [CFG_IW-1:0] REG_DZ0 = 3'd0;
    localparam logic [CFG_IW-1:0] REG_DZ1 = 3'd1;
    localparam logic [CFG_IW-1:0] REG_DZ2 = 3'd2;
    localparam logic [CFG_IW-1:0] REG_DZ3 = 3'd3;
    localparam logic [CFG_IW-1:0] REG_THR = 3'd4;

    localparam logic [DZ_W-1:0] DZ_RESET  = 14'd3277;
    localparam logic [TH_W-1:0] THR_RESET = 16'd4915;

    typedef struct packed {
        logic [1:0]         pad;
        logic               known;
        logic [DZ_W-1:0]    dz;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic [14:0]        lt;
        logic [14:0]        rt;
    } t_item;

    typedef struct packed {
        logic [9:0]                 flags;
        logic [AXES-1:0][AX_W-1:0]  ax;
    } t_row;

    function automatic logic [15:0] abs16(input logic signed [15:0] v);
        return v[15] ? 16'(-v) : 16'(v);
    endfunction

endpackage

>>> hdl/gsdc_front.sv
module gsdc_front #(
    parameter int PADS = gsdc_pkg::PADS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  logic [gsdc_pkg::IN_W-1:0]                  i_data,
    input  logic [3:0][gsdc_pkg::DZ_W-1:0]             i_dz,
    output logic                                       o_valid,
    output gsdc_pkg::t_item                            o_item,
    input  logic                                       i_pop
);
    import gsdc_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_push;

    always_comb begin
        w_item.pad   = i_data[1:0];
        w_item.known = (int'(i_data[1:0]) < PADS);
        w_item.dz    = i_dz[i_data[1:0]];
        w_item.lx    = i_data[17:2];
        w_item.ly    = i_data[33:18];
        w_item.rx    = i_data[49:34];
        w_item.ry    = i_data[65:50];
        w_item.lt    = i_data[80:66];
        w_item.rt    = i_data[95:81];
    end

    assign o_ready = (r_cnt != 2'd2);
    assign w_push  = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= 2'(r_cnt + {1'b0, w_push} - {1'b0, i_pop});
        end
    end

endmodule

>>> hdl/gsdc_core.sv
module gsdc_core #(
    parameter int PADS = gsdc_pkg::PADS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  gsdc_pkg::t_item               i_item,
    output logic                          o_pop,
    input  logic [gsdc_pkg::TH_W-1:0]     i_thr,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [gsdc_pkg::OUT_W-1:0]    o_data
);
    import gsdc_pkg::*;

    localparam int PAD_AW = (PADS > 1) ? $clog2(PADS) : 1;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_RD   = 11'b000_0000_0010,
        ST_SQA  = 11'b000_0000_0100,
        ST_SQB  = 11'b000_0000_1000,
        ST_ROOT = 11'b000_0001_0000,
        ST_CHK  = 11'b000_0010_0000,
        ST_MULN = 11'b000_0100_0000,
        ST_MULD = 11'b000_1000_0000,
        ST_TRG  = 11'b001_0000_0000,
        ST_DIV  = 11'b010_0000_0000,
        ST_FIN  = 11'b100_0000_0000
    } t_state;

    t_state                     r_st, n_st, w_after;
    t_item                      r_item;
    logic [2:0]                 r_job, w_jnx;
    logic [31:0]                r_acc, r_root, r_bit, r_num;
    logic [15:0]                r_m;
    logic [4:0]                 r_cnt;
    logic [48:0]                r_rem, r_dsh;
    logic [17:0]                r_q;
    logic [AXES-1:0][AX_W-1:0]  r_ax;
    t_row                       r_mem [PADS];
    t_row                       r_rd;
    logic                       r_rdv;
    logic [PADS-1:0]            r_valid;
    logic                       r_ov;
    logic [OUT_W-1:0]           r_od;

    logic [3:0]                 w_pad4;
    logic [PAD_AW-1:0]          w_addr;
    logic [15:0]                w_ma, w_mb;
    logic [31:0]                w_prod;
    logic signed [15:0]         w_x, w_y, w_c;
    logic [15:0]                w_dm;
    logic [30:0]                w_tden;
    logic [29:0]                w_tnum;
    logic [28:0]                w_tsub;
    logic [31:0]                w_rsum;
    logic                       w_ge;
    logic [17:0]                w_qn;
    logic [AX_W-1:0]            w_res;
    logic                       w_free;
    logic [9:0]                 w_flags, w_rises;
    logic [5:0]                 w_chg;
    t_row                       w_prev;
    logic signed [17:0]         w_t, w_s [AXES];

    assign w_pad4 = {2'b00, r_item.pad};
    assign w_addr = w_pad4[PAD_AW-1:0];
    assign w_x    = r_job[1] ? r_item.rx : r_item.lx;
    assign w_y    = r_job[1] ? r_item.ry : r_item.ly;
    assign w_c    = r_job[0] ? w_y : w_x;
    assign w_dm   = 16'(17'd32768 - {3'b000, r_item.dz});
    assign w_rsum = r_root + r_bit;
    assign w_ge   = (r_rem >= r_dsh);
    assign w_qn   = {r_q[16:0], w_ge};
    assign w_free = !r_ov || i_ready;
    assign w_tnum = {(r_job[0] ? r_item.rt : r_item.lt), 15'b0};
    assign w_tsub = 29'({r_item.dz, 15'b0}) - 29'(r_item.dz);
    assign w_tden = 31'({w_dm, 15'b0}) - 31'(w_dm);

    always_comb begin
        w_ma = w_x;
        w_mb = w_x;
        case (r_st)
            ST_SQA: begin
                w_ma = abs16(w_x);
                w_mb = abs16(w_x);
            end
            ST_SQB: begin
                w_ma = abs16(w_y);
                w_mb = abs16(w_y);
            end
            ST_MULN: begin
                w_ma = abs16(w_c);
                w_mb = 16'(r_m - {2'b00, r_item.dz});
            end
            ST_MULD: begin
                w_ma = r_m;
                w_mb = w_dm;
            end
            default: begin
                w_ma = 16'd0;
                w_mb = 16'd0;
            end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    always_comb begin
        if (r_job[2]) begin
            w_res = (w_qn > 18'd32768) ? 17'd32768 : w_qn[16:0];
        end else if (w_c[15]) begin
            w_res = (w_qn > 18'd65536) ? 17'h10000 : 17'(-w_qn);
        end else begin
            w_res = (w_qn > 18'd65535) ? 17'h0FFFF : w_qn[16:0];
        end
    end

    always_comb begin
        w_jnx = (r_st == ST_CHK) ? 3'(r_job + 3'd2) : 3'(r_job + 3'd1);
        case (w_jnx)
            3'd1, 3'd3: w_after = ST_MULN;
            3'd2:       w_after = ST_SQA;
            3'd4, 3'd5: w_after = ST_TRG;
            default:    w_after = ST_FIN;
        endcase
    end

    always_comb begin
        w_t = 18'({2'b00, i_thr});
        for (int i = 0; i < AXES; i++) begin
            w_s[i] = 18'(signed'(r_ax[i]));
        end
        w_flags[0] = w_s[1] < -w_t;
        w_flags[1] = w_s[1] > w_t;
        w_flags[2] = w_s[0] < -w_t;
        w_flags[3] = w_s[0] > w_t;
        w_flags[4] = w_s[3] < -w_t;
        w_flags[5] = w_s[3] > w_t;
        w_flags[6] = w_s[2] < -w_t;
        w_flags[7] = w_s[2] > w_t;
        w_flags[8] = w_s[4] > w_t;
        w_flags[9] = w_s[5] > w_t;
        w_prev = r_rdv ? r_rd : '0;
        w_rises = r_item.known ? (w_flags & ~w_prev.flags) : 10'd0;
        for (int i = 0; i < AXES; i++) begin
            w_chg[i] = r_item.known && (r_ax[i] != w_prev.ax[i]);
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (i_valid) n_st = ST_RD;
            ST_RD:   n_st = ST_SQA;
            ST_SQA:  n_st = ST_SQB;
            ST_SQB:  n_st = ST_ROOT;
            ST_ROOT: if (r_cnt == 5'd15) n_st = ST_CHK;
            ST_CHK: begin
                if (r_root[15:0] == 16'd0 || r_root[15:0] < {2'b00, r_item.dz}) begin
                    n_st = w_after;
                end else begin
                    n_st = ST_MULN;
                end
            end
            ST_MULN: n_st = ST_MULD;
            ST_MULD: n_st = ST_DIV;
            ST_TRG:  n_st = (w_tnum <= 30'(w_tsub)) ? w_after : ST_DIV;
            ST_DIV:  if (r_cnt == 5'd17) n_st = w_after;
            ST_FIN:  if (w_free) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    assign o_pop = (r_st == ST_IDLE) && i_valid;

    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                r_item <= i_item;
                r_job  <= 3'd0;
            end
            ST_RD: begin
                r_rd  <= r_mem[w_addr];
                r_rdv <= r_item.known && r_valid[w_addr];
            end
            ST_SQA: r_acc <= w_prod;
            ST_SQB: begin
                r_acc  <= r_acc + w_prod;
                r_root <= 32'd0;
                r_bit  <= 32'h4000_0000;
                r_cnt  <= 5'd0;
            end
            ST_ROOT: begin
                if (r_acc >= w_rsum) begin
                    r_acc  <= r_acc - w_rsum;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= 5'(r_cnt + 5'd1);
            end
            ST_CHK: begin
                r_m <= r_root[15:0];
                if (r_root[15:0] == 16'd0 || r_root[15:0] < {2'b00, r_item.dz}) begin
                    r_ax[{1'b0, r_job[1], 1'b0}] <= '0;
                    r_ax[{1'b0, r_job[1], 1'b1}] <= '0;
                    r_job <= w_jnx;
                end
            end
            ST_MULN: r_num <= w_prod;
            ST_MULD: begin
                r_rem <= 49'({r_num, 15'b0}) + 49'(w_prod >> 1);
                r_dsh <= 49'({w_prod, 17'b0});
                r_q   <= 18'd0;
                r_cnt <= 5'd0;
            end
            ST_TRG: begin
                if (w_tnum <= 30'(w_tsub)) begin
                    r_ax[r_job] <= '0;
                    r_job <= w_jnx;
                end
                r_rem <= 49'({30'(w_tnum - 30'(w_tsub)), 15'b0}) + 49'(w_tden >> 1);
                r_dsh <= 49'({w_tden, 17'b0});
                r_q   <= 18'd0;
                r_cnt <= 5'd0;
            end
            ST_DIV: begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_dsh <= r_dsh >> 1;
                r_q   <= w_qn;
                r_cnt <= 5'(r_cnt + 5'd1);
                if (r_cnt == 5'd17) begin
                    r_ax[r_job] <= w_res;
                    r_job <= w_jnx;
                end
            end
            ST_FIN: begin
                if (w_free) begin
                    r_od <= {w_chg, w_rises, w_flags, r_ax[5][15:0], r_ax[4][15:0],
                             r_ax[3], r_ax[2], r_ax[1], r_ax[0], r_item.pad};
                    if (r_item.known) begin
                        r_mem[w_addr] <= {w_flags, r_ax};
                    end
                end
            end
            default: r_job <= r_job;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_ov    <= 1'b0;
            r_valid <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == ST_FIN && w_free) begin
                r_ov <= 1'b1;
                if (r_item.known) begin
                    r_valid[w_addr] <= 1'b1;
                end
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;

`ifndef SYNTHESIS
    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_FIN && w_free) |=> r_ov) else $error("result not loaded");
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_CHK) |-> (r_root <= 32'd46341)) else $error("root out of range");
    a_job_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_RD) |-> (r_job == 3'd0)) else $error("job not cleared");
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DIV) |-> (r_cnt <= 5'd17)) else $error("divider overrun");
`endif

endmodule

>>> hdl/gamepad_stick_deadzone_conditioner.sv
// Channel    Direction  Handshake                       Payload
// s_axis     in         i_s_axis_tvalid/o_s_axis_tready  one polled pad frame
// m_axis     out        o_m_axis_tvalid/i_m_axis_tready  conditioned frame
// cfg        in         i_cfg_valid/o_cfg_ready          register index, data
//
// The time one item takes is set by the 16-step square root per
// stick and the 18-step divider per axis; sticks inside the dead zone and
// released triggers skip their divides. A two-entry queue takes items while
// the core works; a result waits in its output register without blocking the
// core until the next result is ready. Synchronous active-low reset.
module gamepad_stick_deadzone_conditioner #(
    parameter int PADS = gsdc_pkg::PADS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // pad_index, left_x_in, left_y_in, right_x_in, right_y_in,
    // left_trigger_in, right_trigger_in
    input  logic [gsdc_pkg::IN_W-1:0]     i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // pad_out, left_x_out, left_y_out, right_x_out, right_y_out,
    // left_trigger_out, right_trigger_out, direction_flags,
    // direction_rises, axes_changed
    output logic [gsdc_pkg::OUT_W-1:0]    o_m_axis_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gsdc_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [gsdc_pkg::CFG_DW-1:0]   i_cfg_data
);
    import gsdc_pkg::*;

    logic [3:0][DZ_W-1:0] r_dz;
    logic [TH_W-1:0]      r_thr;
    logic                 w_qv, w_pop;
    t_item                w_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz  <= {4{DZ_RESET}};
            r_thr <= THR_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DZ0: r_dz[0] <= i_cfg_data[DZ_W-1:0];
                REG_DZ1: r_dz[1] <= i_cfg_data[DZ_W-1:0];
                REG_DZ2: r_dz[2] <= i_cfg_data[DZ_W-1:0];
                REG_DZ3: r_dz[3] <= i_cfg_data[DZ_W-1:0];
                REG_THR: r_thr   <= i_cfg_data[TH_W-1:0];
                default: r_thr   <= r_thr;
            endcase
        end
    end

    gsdc_front #(.PADS(PADS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .i_dz    (r_dz),
        .o_valid (w_qv),
        .o_item  (w_item),
        .i_pop   (w_pop)
    );

    gsdc_core #(.PADS(PADS)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qv),
        .i_item  (w_item),
        .o_pop   (w_pop),
        .i_thr   (r_thr),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule

>>> tb/sv/gamepad_stick_deadzone_conditioner_test.sv
module gamepad_stick_deadzone_conditioner_test;
    import gsdc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  pad;
        logic [16:0] lx;
        logic [16:0] ly;
        logic [16:0] rx;
        logic [16:0] ry;
        logic [15:0] lt;
        logic [15:0] rt;
        logic [9:0]  flags;
        logic [9:0]  rises;
        logic [5:0]  changed;
    } t_frame_out;

    typedef struct {
        logic [1:0]  pad;
        logic [15:0] lx, ly, rx, ry;
        logic [14:0] lt, rt;
        bit          chk;
        t_frame_out  want;
    } t_row_stim;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [IN_W-1:0]    i_s_axis_tdata = '0;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   o_m_axis_tdata;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_IW-1:0]  i_cfg_index = '0;
    logic [CFG_DW-1:0]  i_cfg_data = '0;

    gamepad_stick_deadzone_conditioner dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [13:0] dz_model [4];
    logic [15:0] thr_model;
    int          prev_axis [PADS_DEF][AXES];
    logic [9:0]  prev_flags [PADS_DEF];
    t_frame_out  frames_due [$];
    int          errors = 0;
    int          received = 0;

    function automatic longint root_floor(longint v);
        longint r, b;
        r = 0;
        b = 64'd1 << 32;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int scale_axis(int c, longint m, longint d);
        longint a, den, q;
        a = (c < 0) ? -c : c;
        den = m * (32768 - d);
        q = (a * (m - d) * 32768 + den / 2) / den;
        if (c < 0) return (q > 65536) ? -65536 : -int'(q);
        return (q > 65535) ? 65535 : int'(q);
    endfunction

    function automatic void shape_stick(int x, int y, int d, output int ox, output int oy);
        longint m;
        m = root_floor(longint'(x) * x + longint'(y) * y);
        if (m == 0 || m < d) begin
            ox = 0;
            oy = 0;
        end else begin
            ox = scale_axis(x, m, d);
            oy = scale_axis(y, m, d);
        end
    endfunction

    function automatic int shape_trigger(int raw, int d);
        longint num, sub, den, q;
        num = longint'(raw) * 32768;
        sub = longint'(d) * 32767;
        den = 32767 * longint'(32768 - d);
        if (num <= sub) return 0;
        q = ((num - sub) * 32768 + den / 2) / den;
        return (q > 32768) ? 32768 : int'(q);
    endfunction

    function automatic logic [3:0] stick_dirs(int x, int y, int t);
        return {x > t, x < -t, y > t, y < -t};
    endfunction

    function automatic t_frame_out condition_frame(logic [1:0] pad, logic [15:0] lx,
            logic [15:0] ly, logic [15:0] rx, logic [15:0] ry, logic [14:0] lt,
            logic [14:0] rt);
        t_frame_out r;
        int ax [AXES];
        int d, t;
        d = dz_model[pad];
        t = thr_model;
        shape_stick(int'($signed(lx)), int'($signed(ly)), d, ax[0], ax[1]);
        shape_stick(int'($signed(rx)), int'($signed(ry)), d, ax[2], ax[3]);
        ax[4] = shape_trigger(lt, d);
        ax[5] = shape_trigger(rt, d);
        r.pad = pad;
        r.lx = ax[0][16:0];
        r.ly = ax[1][16:0];
        r.rx = ax[2][16:0];
        r.ry = ax[3][16:0];
        r.lt = ax[4][15:0];
        r.rt = ax[5][15:0];
        r.flags = {ax[5] > t, ax[4] > t, stick_dirs(ax[2], ax[3], t),
                   stick_dirs(ax[0], ax[1], t)};
        r.rises = r.flags & ~prev_flags[pad];
        prev_flags[pad] = r.flags;
        r.changed = '0;
        for (int j = 0; j < AXES; j++) begin
            if (ax[j] != prev_axis[pad][j]) r.changed[j] = 1'b1;
            prev_axis[pad][j] = ax[j];
        end
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx < REG_THR) dz_model[idx] = val[13:0];
        else if (idx == REG_THR) thr_model = val;
        @(negedge i_clk);
    endtask

    task automatic send_frame(logic [1:0] pad, logic [15:0] lx, logic [15:0] ly,
            logic [15:0] rx, logic [15:0] ry, logic [14:0] lt, logic [14:0] rt,
            bit chk, t_frame_out want);
        t_frame_out p;
        int n;
        n = $urandom_range(0, 13) * ($urandom_range(0, 3) != 0);
        if (n != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        p = condition_frame(pad, lx, ly, rx, ry, lt, rt);
        if (chk && p != want) begin
            errors++;
            if (errors <= 10)
                $display("table row mismatch: table %h predictor %h", want, p);
        end
        frames_due = {frames_due, p};
        i_s_axis_tdata <= {2'b00, rt, lt, ry, rx, ly, lx, pad};
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (frames_due.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic random_frames(int n);
        logic [15:0] v [4];
        logic [14:0] lt, rt;
        int mode;
        for (int i = 0; i < n; i++) begin
            mode = $urandom_range(0, 5);
            for (int k = 0; k < 4; k++) begin
                case (mode)
                    0: v[k] = 16'($signed($urandom_range(0, 8000)) - 4000);
                    1: v[k] = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                    default: v[k] = 16'($urandom);
                endcase
            end
            lt = (mode == 0) ? 15'($urandom_range(0, 6000)) : 15'($urandom);
            rt = (mode == 1) ? 15'h7fff : 15'($urandom);
            send_frame(2'($urandom), v[0], v[1], v[2], v[3], lt, rt, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_out got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[$bits(t_frame_out)-1:0];
            got = {o_m_axis_tdata[1:0], o_m_axis_tdata[18:2], o_m_axis_tdata[35:19],
                   o_m_axis_tdata[52:36], o_m_axis_tdata[69:53], o_m_axis_tdata[85:70],
                   o_m_axis_tdata[101:86], o_m_axis_tdata[111:102],
                   o_m_axis_tdata[121:112], o_m_axis_tdata[127:122]};
            received++;
            if (frames_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected item: %h", got);
            end else begin
                want = frames_due.pop_front();
                if (got != want) begin
                    errors++;
                    if (errors <= 10) $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    initial begin
        int n;
        forever begin
            n = $urandom_range(0, 13);
            if (n != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_axis_tvalid && i_m_axis_tready));
            @(negedge i_clk);
        end
    end

    t_row_stim rows [$];

    function automatic t_frame_out expect_row(logic [1:0] pad, logic [16:0] lx,
            logic [16:0] ly, logic [16:0] rx, logic [16:0] ry, logic [15:0] lt,
            logic [15:0] rt, logic [9:0] fl, logic [9:0] ri, logic [5:0] ch);
        t_frame_out r;
        r = {pad, lx, ly, rx, ry, lt, rt, fl, ri, ch};
        return r;
    endfunction

    function automatic void add_row(logic [1:0] pad, logic [15:0] lx, logic [15:0] ly,
            logic [15:0] rx, logic [15:0] ry, logic [14:0] lt, logic [14:0] rt,
            bit chk, t_frame_out want);
        t_row_stim r;
        r.pad = pad; r.lx = lx; r.ly = ly; r.rx = rx; r.ry = ry;
        r.lt = lt; r.rt = rt; r.chk = chk; r.want = want;
        rows = {rows, r};
    endfunction

    initial begin
        for (int i = 0; i < 4; i++) dz_model[i] = DZ_RESET;
        thr_model = THR_RESET;
        for (int p = 0; p < PADS_DEF; p++) begin
            prev_flags[p] = '0;
            for (int j = 0; j < AXES; j++) prev_axis[p][j] = 0;
        end
        add_row(2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'd0, 15'd0, 1'b1,
                expect_row(2'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(2'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'h7fff, 15'h7fff, 1'b1,
                expect_row(2'd1, 0, 0, 0, 0, 16'd32768, 16'd32768, 10'h300, 10'h300,
                           6'h30));
        add_row(2'd2, 16'h8000, 16'h0000, 16'h7fff, 16'h0000, 15'd0, 15'd0, 1'b0, '0);
        add_row(2'd3, 16'h0000, 16'h8000, 16'h0000, 16'h7fff, 15'd1, 15'd3000, 1'b0, '0);
        add_row(2'd0, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 15'd5000, 15'd20000,
                1'b0, '0);
        add_row(2'd0, 16'd100, 16'hff00, 16'd3000, 16'd3000, 15'd3277, 15'd3278, 1'b0, '0);
        add_row(2'd1, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 15'h5555, 15'h2aaa,
                1'b0, '0);
        add_row(2'd2, 16'hffff, 16'h0001, 16'h0001, 16'hffff, 15'd10000, 15'd0, 1'b0, '0);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rows[i])
            send_frame(rows[i].pad, rows[i].lx, rows[i].ly, rows[i].rx, rows[i].ry,
                       rows[i].lt, rows[i].rt, rows[i].chk, rows[i].want);
        drain();
        write_reg(REG_DZ0, 16'd0);
        write_reg(REG_DZ1, 16'd16383);
        write_reg(REG_DZ2, 16'd1);
        write_reg(REG_DZ3, 16'hffff);
        write_reg(REG_THR, 16'd0);
        write_reg(3'd7, 16'h1234);
        send_frame(2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'd0, 15'd0,
                   1'b0, '0);
        send_frame(2'd1, 16'h7fff, 16'h8000, 16'h0001, 16'h0000, 15'h7fff, 15'd1,
                   1'b0, '0);
        send_frame(2'd3, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 15'h7fff, 15'h4000,
                   1'b0, '0);
        random_frames(300);
        drain();
        write_reg(REG_THR, 16'd32768);
        random_frames(250);
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            for (int k = 0; k < 5; k++)
                write_reg(CFG_IW'(k), (k == 4) ? 16'($urandom_range(0, 32768))
                                               : 16'($urandom));
            random_frames(250);
            drain();
        end
        write_reg(REG_DZ0, 16'(DZ_RESET));
        write_reg(REG_DZ1, 16'(DZ_RESET));
        write_reg(REG_DZ2, 16'(DZ_RESET));
        write_reg(REG_DZ3, 16'(DZ_RESET));
        write_reg(REG_THR, THR_RESET);
        random_frames(1);
        drain();
        if (errors == 0 && frames_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
hdl/gsdc_pkg.sv
hdl/gsdc_front.sv
hdl/gsdc_core.sv
hdl/gamepad_stick_deadzone_conditioner.sv
tb/sv/gamepad_stick_deadzone_conditioner_test.sv
